// ===== rtl/max_pool_with_argmax_macros.svh =====
// ----------------------------------------------------------------------------
// max_pool_with_argmax macros: assertion helpers
// concurrent checks clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_WITH_ARGMAX_MACROS_SVH
`define MAX_POOL_WITH_ARGMAX_MACROS_SVH

// same-cycle implication
`define MPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpa check failed");

// next-cycle implication
`define MPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpa check failed");

`endif

// ===== rtl/mpa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants for max pooling with argmax
// register codes, field widths, scan flags and default sizes
// ----------------------------------------------------------------------------
`default_nettype none

package mpa_pkg;

	localparam int DEF_MAX_ROWS     = 256;
	localparam int DEF_MAX_COLS     = 256;
	localparam int DEF_MAX_POOL     = 8;
	localparam int DEF_MAX_MAPS     = 256;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int DIM_REG_W   = 9;
	localparam int POOL_REG_W  = 4;
	localparam int STACK_W     = 24;
	localparam int SRC_INDEX_W = 25;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAP_ROWS  = 3'd0,
		REG_MAP_COLS  = 3'd1,
		REG_POOL_SIZE = 3'd2,
		REG_MAP_COUNT = 3'd3
	} cfg_reg_t;

	// per-sample flags from the scan counters
	typedef struct packed {
		logic first;       // first sample of its tile
		logic done;        // last sample of its tile
		logic end_of_map;  // last sample of its map
	} scan_flags_t;

	// bits needed to index n entries, at least one
	function automatic int cw(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/max_pool_with_argmax.sv =====
// ----------------------------------------------------------------------------
// max_pool_with_argmax: streaming square max pooling with argmax
// results pass the compare stage and output register; accepts one sample per cycle
// unless out_stall holds a result, set by the tile store read-compare-write
// reset: stream restarts at stack start, registers at defaults, tile stores kept
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_with_argmax_macros.svh"

module max_pool_with_argmax #(
	parameter int MAX_ROWS     = mpa_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS     = mpa_pkg::DEF_MAX_COLS,
	parameter int MAX_POOL     = mpa_pkg::DEF_MAX_POOL,
	parameter int MAX_MAPS     = mpa_pkg::DEF_MAX_MAPS,
	parameter int SAMPLE_WIDTH = mpa_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mpa_pkg::CFG_DATA_W-1:0]       cfg_data,
	// sample stream
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	// pooled results
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       pooled_max,
	output logic [mpa_pkg::SRC_INDEX_W-1:0]      source_index,
	output logic                                 end_of_map
);
	import mpa_pkg::*;

	localparam int TW = cw(MAX_ROWS);

	logic                           acc;
	logic                           adv;
	logic [TW-1:0]                  tile;
	logic [STACK_W-1:0]             stack_pos;
	scan_flags_t                    flags;
	logic                           s1_valid;
	logic                           res_done;
	logic                           res_eom;
	logic signed [SAMPLE_WIDTH-1:0] res_max;
	logic [STACK_W-1:0]             res_index;
	logic                           out_valid_q;

	// register writes are taken at any time
	assign cfg_ready = 1'b1;

	// compare stage moves on when the output register is free or draining
	assign adv      = s1_valid && (!out_valid_q || !out_stall);
	// a new sample enters whenever the compare stage is empty or empties this cycle
	assign in_stall = s1_valid && !adv;
	assign acc      = in_valid && !in_stall;

	// scan position and tile boundary detection
	mpa_scan_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_POOL (MAX_POOL),
		.MAX_MAPS (MAX_MAPS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.tile      (tile),
		.stack_pos (stack_pos),
		.flags     (flags)
	);

	// running maximum per tile of the current stripe
	mpa_tile_store #(
		.MAX_ROWS     (MAX_ROWS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.adv       (adv),
		.sample    (sample),
		.tile      (tile),
		.stack_pos (stack_pos),
		.flags     (flags),
		.s1_valid  (s1_valid),
		.res_done  (res_done),
		.res_eom   (res_eom),
		.res_max   (res_max),
		.res_index (res_index)
	);

	// output register: loads when a finished tile leaves the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_done;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only changes on a load, so a stalled transaction holds
	always_ff @(posedge clk) begin
		if (adv && res_done) begin
			pooled_max   <= res_max;
			source_index <= SRC_INDEX_W'(res_index) + 1'b1;
			end_of_map   <= res_eom;
		end
	end

	assign out_valid = out_valid_q;

	`MPA_ASSERT_NOW(a_no_stall_when_empty, !s1_valid, !in_stall)
	`MPA_ASSERT_NEXT(a_done_reaches_output, adv && res_done, out_valid)
	`MPA_ASSERT_NOW(a_index_one_based, out_valid, source_index != '0)

endmodule

`default_nettype wire

// ===== rtl/mpa_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpa_scan_ctrl: configuration registers and scan position counters
// tracks row, tile, column and map of the next sample, flags tile boundaries
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_with_argmax_macros.svh"

module mpa_scan_ctrl #(
	parameter int MAX_ROWS = mpa_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = mpa_pkg::DEF_MAX_COLS,
	parameter int MAX_POOL = mpa_pkg::DEF_MAX_POOL,
	parameter int MAX_MAPS = mpa_pkg::DEF_MAX_MAPS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [mpa_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [mpa_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   acc,
	output logic [mpa_pkg::cw(MAX_ROWS)-1:0]       tile,
	output logic [mpa_pkg::STACK_W-1:0]            stack_pos,
	output mpa_pkg::scan_flags_t                   flags
);
	import mpa_pkg::*;

	localparam int RW = cw(MAX_ROWS);
	localparam int CW = cw(MAX_COLS);
	localparam int PW = cw(MAX_POOL);
	localparam int MW = cw(MAX_MAPS);

	// configuration, held as value minus one
	logic [RW-1:0] rows_m1_q;
	logic [CW-1:0] cols_m1_q;
	logic [PW-1:0] pool_m1_q;
	logic [MW-1:0] maps_m1_q;

	logic [RW-1:0] row_q;
	logic [PW-1:0] tro_q;
	logic [RW-1:0] tile_q;
	logic [CW-1:0] col_q;
	logic [PW-1:0] cis_q;
	logic [MW-1:0] map_q;
	logic [STACK_W-1:0] stack_q;

	logic row_last, col_last, tro_last, cis_last, map_last;

	// zero reads as one, too large reads as the maximum
	function automatic int unsigned clamp_m1(input int unsigned v, input int unsigned hi);
		if (v == 0) return 0;
		if (v > hi) return hi - 1;
		return v - 1;
	endfunction

	assign row_last = (row_q == rows_m1_q);
	assign col_last = (col_q == cols_m1_q);
	assign tro_last = (tro_q == pool_m1_q);
	assign cis_last = (cis_q == pool_m1_q);
	assign map_last = (map_q == maps_m1_q);

	assign flags.first      = (cis_q == '0) && (tro_q == '0);
	assign flags.done       = (tro_last || row_last) && (cis_last || col_last);
	assign flags.end_of_map = row_last && col_last;
	assign tile             = tile_q;
	assign stack_pos        = stack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q <= '0;
			cols_m1_q <= '0;
			pool_m1_q <= PW'(clamp_m1(2, MAX_POOL));
			maps_m1_q <= '0;
			row_q     <= '0;
			tro_q     <= '0;
			tile_q    <= '0;
			col_q     <= '0;
			cis_q     <= '0;
			map_q     <= '0;
			stack_q   <= '0;
		end else if (cfg_valid) begin
			// any known register write restarts the stream
			unique case (cfg_index)
				REG_MAP_ROWS:  rows_m1_q <= RW'(clamp_m1(32'(cfg_data[DIM_REG_W-1:0]), MAX_ROWS));
				REG_MAP_COLS:  cols_m1_q <= CW'(clamp_m1(32'(cfg_data[DIM_REG_W-1:0]), MAX_COLS));
				REG_POOL_SIZE: pool_m1_q <= PW'(clamp_m1(32'(cfg_data[POOL_REG_W-1:0]), MAX_POOL));
				REG_MAP_COUNT: maps_m1_q <= MW'(clamp_m1(32'(cfg_data[DIM_REG_W-1:0]), MAX_MAPS));
				default: ;
			endcase
			if (cfg_index == REG_MAP_ROWS || cfg_index == REG_MAP_COLS ||
			    cfg_index == REG_POOL_SIZE || cfg_index == REG_MAP_COUNT) begin
				row_q   <= '0;
				tro_q   <= '0;
				tile_q  <= '0;
				col_q   <= '0;
				cis_q   <= '0;
				map_q   <= '0;
				stack_q <= '0;
			end
		end else if (acc) begin
			if (row_last) begin
				row_q  <= '0;
				tro_q  <= '0;
				tile_q <= '0;
				if (col_last) begin
					col_q <= '0;
					cis_q <= '0;
					if (map_last) begin
						map_q   <= '0;
						stack_q <= '0;
					end else begin
						map_q   <= map_q + 1'b1;
						stack_q <= stack_q + 1'b1;
					end
				end else begin
					col_q   <= col_q + 1'b1;
					cis_q   <= cis_last ? '0 : cis_q + 1'b1;
					stack_q <= stack_q + 1'b1;
				end
			end else begin
				row_q   <= row_q + 1'b1;
				stack_q <= stack_q + 1'b1;
				if (tro_last) begin
					tro_q  <= '0;
					tile_q <= tile_q + 1'b1;
				end else begin
					tro_q <= tro_q + 1'b1;
				end
			end
		end
	end

	`MPA_ASSERT_NOW(a_row_in_map, 1'b1, row_q <= rows_m1_q)
	`MPA_ASSERT_NOW(a_col_in_map, 1'b1, col_q <= cols_m1_q)
	`MPA_ASSERT_NOW(a_tro_in_tile, 1'b1, tro_q <= pool_m1_q && cis_q <= pool_m1_q)

endmodule

`default_nettype wire

// ===== rtl/mpa_tile_store.sv =====
// ----------------------------------------------------------------------------
// mpa_tile_store: per-tile running maximum and argmax for the column stripe
// read at accept into the compare stage, compare and write back as the item leaves it, with forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module mpa_tile_store #(
	parameter int MAX_ROWS     = mpa_pkg::DEF_MAX_ROWS,
	parameter int SAMPLE_WIDTH = mpa_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                acc,
	input  logic                                adv,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	input  logic [mpa_pkg::cw(MAX_ROWS)-1:0]    tile,
	input  logic [mpa_pkg::STACK_W-1:0]         stack_pos,
	input  mpa_pkg::scan_flags_t                flags,
	output logic                                s1_valid,
	output logic                                res_done,
	output logic                                res_eom,
	output logic signed [SAMPLE_WIDTH-1:0]      res_max,
	output logic [mpa_pkg::STACK_W-1:0]         res_index
);
	import mpa_pkg::*;

	localparam int TW = cw(MAX_ROWS);

	logic signed [SAMPLE_WIDTH-1:0] max_mem [MAX_ROWS];
	logic [STACK_W-1:0]             idx_mem [MAX_ROWS];

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic [TW-1:0]                  tile_s1;
	logic [STACK_W-1:0]             stack_s1;
	scan_flags_t                    flags_s1;
	logic signed [SAMPLE_WIDTH-1:0] rd_max_s1;
	logic [STACK_W-1:0]             rd_idx_s1;
	logic                           fwd_hit_s1;
	logic signed [SAMPLE_WIDTH-1:0] fwd_max_s1;
	logic [STACK_W-1:0]             fwd_idx_s1;

	logic signed [SAMPLE_WIDTH-1:0] cur_max;
	logic [STACK_W-1:0]             cur_idx;
	logic                           take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1  <= sample;
			tile_s1    <= tile;
			stack_s1   <= stack_pos;
			flags_s1   <= flags;
			rd_max_s1  <= max_mem[tile];
			rd_idx_s1  <= idx_mem[tile];
			// the item leaving now writes the entry being read
			fwd_hit_s1 <= valid_s1 && (tile_s1 == tile);
			fwd_max_s1 <= res_max;
			fwd_idx_s1 <= res_index;
		end
		if (adv) begin
			max_mem[tile_s1] <= res_max;
			idx_mem[tile_s1] <= res_index;
		end
	end

	assign cur_max = fwd_hit_s1 ? fwd_max_s1 : rd_max_s1;
	assign cur_idx = fwd_hit_s1 ? fwd_idx_s1 : rd_idx_s1;
	assign take    = flags_s1.first || (sample_s1 > cur_max);

	assign res_max   = take ? sample_s1 : cur_max;
	assign res_index = take ? stack_s1 : cur_idx;
	assign res_done  = flags_s1.done;
	assign res_eom   = flags_s1.end_of_map;
	assign s1_valid  = valid_s1;

endmodule

`default_nettype wire

// ===== tb/sv/max_pool_with_argmax_checker.sv =====
// ----------------------------------------------------------------------------
// max_pool_with_argmax_checker: tile maximum predictor and result comparison
// watches the configuration, sample and result channels, keeps its own scan
// position and tile stores, and compares every pooled result with the oldest
// tile expected to finish
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_with_argmax_checker (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	input  wire logic                                   cfg_ready,
	input  wire logic [mpa_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [mpa_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	input  wire logic                                   in_stall,
	input  wire logic signed [mpa_pkg::DEF_SAMPLE_WIDTH-1:0] sample,
	input  wire logic                                   out_valid,
	input  wire logic                                   out_stall,
	input  wire logic signed [mpa_pkg::DEF_SAMPLE_WIDTH-1:0] pooled_max,
	input  wire logic [mpa_pkg::SRC_INDEX_W-1:0]        source_index,
	input  wire logic                                   end_of_map,
	output int                                          errors,
	output int                                          pending
);
	import mpa_pkg::*;

	localparam int SW = DEF_SAMPLE_WIDTH;

	typedef struct {
		logic signed [SW-1:0]   pooled_max;
		logic [SRC_INDEX_W-1:0] source_index;
		logic                   end_of_map;
	} tile_result_t;

	tile_result_t         finished_tiles[$];
	logic signed [SW-1:0] tile_max [DEF_MAX_ROWS];
	logic [STACK_W-1:0]   tile_src [DEF_MAX_ROWS];

	int unsigned rows, cols, pool, maps;
	int unsigned row_pos, col_pos, col_in_stripe, map_pos;
	logic [STACK_W-1:0] stack_pos;
	int fail_count;

	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic restart_scan();
		row_pos = 0;
		col_pos = 0;
		col_in_stripe = 0;
		map_pos = 0;
		stack_pos = '0;
	endtask

	task automatic write_setting(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		unique case (index)
			REG_MAP_ROWS: begin
				rows = clamp_reg(32'(data), DEF_MAX_ROWS);
				restart_scan();
			end
			REG_MAP_COLS: begin
				cols = clamp_reg(32'(data), DEF_MAX_COLS);
				restart_scan();
			end
			REG_POOL_SIZE: begin
				pool = clamp_reg(32'(data[POOL_REG_W-1:0]), DEF_MAX_POOL);
				restart_scan();
			end
			REG_MAP_COUNT: begin
				maps = clamp_reg(32'(data), DEF_MAX_MAPS);
				restart_scan();
			end
			default: begin
				// unknown index leaves settings and scan position alone
			end
		endcase
	endtask

	// fold one sample into its tile, queue the tile if it just finished
	task automatic pool_sample(input logic signed [SW-1:0] s);
		int unsigned off, tile;
		logic first, last_row, last_col, wrapped;
		tile_result_t r;
		off = row_pos % pool;
		tile = row_pos / pool;
		if (tile >= DEF_MAX_ROWS)
			tile = DEF_MAX_ROWS - 1;
		first = (col_in_stripe == 0) && (off == 0);
		if (first || s > tile_max[tile]) begin
			tile_max[tile] = s;
			tile_src[tile] = stack_pos;
		end
		last_row = (off == pool - 1) || (row_pos + 1 >= rows);
		last_col = (col_in_stripe + 1 >= pool) || (col_pos + 1 >= cols);
		if (last_row && last_col) begin
			r.pooled_max = tile_max[tile];
			r.source_index = {1'b0, tile_src[tile]} + 1'b1;
			r.end_of_map = (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
			finished_tiles.push_back(r);
		end
		wrapped = 1'b0;
		row_pos++;
		if (row_pos >= rows) begin
			row_pos = 0;
			col_pos++;
			col_in_stripe++;
			if (col_in_stripe >= pool)
				col_in_stripe = 0;
			if (col_pos >= cols) begin
				col_pos = 0;
				col_in_stripe = 0;
				map_pos++;
				if (map_pos >= maps) begin
					restart_scan();
					wrapped = 1'b1;
				end
			end
		end
		if (!wrapped)
			stack_pos = stack_pos + 1'b1;
	endtask

	task automatic check_result();
		tile_result_t want;
		if (finished_tiles.size() == 0) begin
			$error("result with no tile pending: pooled_max %0d, source_index %0d",
				pooled_max, source_index);
			fail_count++;
		end else begin
			want = finished_tiles.pop_front();
			if (pooled_max !== want.pooled_max) begin
				$error("pooled_max: expected %0d, actual %0d", want.pooled_max, pooled_max);
				fail_count++;
			end
			if (source_index !== want.source_index) begin
				$error("source_index: expected %0d, actual %0d",
					want.source_index, source_index);
				fail_count++;
			end
			if (end_of_map !== want.end_of_map) begin
				$error("end_of_map: expected %0d, actual %0d", want.end_of_map, end_of_map);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows = 1;
			cols = 1;
			pool = 2;
			maps = 1;
			restart_scan();
			finished_tiles.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_valid && cfg_ready)
				write_setting(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				pool_sample(sample);
			errors <= fail_count;
			pending <= finished_tiles.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/max_pool_with_argmax_test.sv =====
// ----------------------------------------------------------------------------
// max_pool_with_argmax_test: stimulus and verdict for max pooling with argmax
// drives map sizes, tile sizes and sample streams through the block under
// several idle and stall patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_with_argmax_test;
	import mpa_pkg::*;

	localparam int SW            = DEF_SAMPLE_WIDTH;
	localparam int REG_COUNT     = 4;       // indexes at or above this are unused
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;     // receiver hold-off, long enough to fill the block
	localparam int LIMIT_CYCLES  = 300000;
	localparam int RANDOM_PHASES = 9;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [SW-1:0]   sample = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [SW-1:0]   pooled_max;
	logic [SRC_INDEX_W-1:0] source_index;
	logic                   end_of_map;

	int errors;
	int pending;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_id = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;
	int phase_no = 0;

	// second map of the directed part: ties, a late maximum, ragged edge tiles
	logic signed [SW-1:0] mixed_map [9] = '{16'sd5, 16'sd5, 16'sh7FFF, 16'sd5, 16'sd5,
		-16'sd1, 16'sd0, 16'sh7FFF, 16'sd0};

	max_pool_with_argmax dut (.*);

	max_pool_with_argmax_checker pool_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit, counted in cycles
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_id) begin
			// new hold request from the sender side
			hold_seen <= hold_id;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		tx_idle_pct = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_BOTH) ? 15 : 0;
		rx_stall_pct <= (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 15 : 0;
	endtask

	// one sample transaction, with random idle cycles before it
	task automatic send_sample(input logic signed [SW-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// stop sending and wait until every pooled result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// new sizes; every write restarts the scan, often in the middle of a map
	task automatic configure(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
			input logic [CFG_DATA_W-1:0] pool, input logic [CFG_DATA_W-1:0] maps);
		settle();
		set_idle(idle_mode_t'(phase_no % 4));
		phase_no++;
		write_reg(REG_MAP_ROWS, rows);
		write_reg(REG_MAP_COLS, cols);
		write_reg(REG_POOL_SIZE, pool);
		write_reg(REG_MAP_COUNT, maps);
		cfg_valid <= 1'b0;
	endtask

	// mostly in range, sometimes zero or past the maximum
	function automatic logic [CFG_DATA_W-1:0] random_dim(input int hi);
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? CFG_DATA_W'($urandom_range(257, 511)) : '0;
		return CFG_DATA_W'($urandom_range(1, hi));
	endfunction

	// low bits hold the tile side, upper bits are junk the block must drop
	function automatic logic [CFG_DATA_W-1:0] random_pool();
		logic [POOL_REG_W-1:0] side;
		logic [CFG_DATA_W-POOL_REG_W-1:0] junk;
		if ($urandom_range(5) == 0)
			side = $urandom_range(1) ? POOL_REG_W'($urandom_range(9, 15)) : '0;
		else
			side = POOL_REG_W'($urandom_range(1, DEF_MAX_POOL));
		junk = ($urandom_range(3) == 0) ? (CFG_DATA_W-POOL_REG_W)'($urandom) : '0;
		return {junk, side};
	endfunction

	// full range, extremes, or a narrow band that forces ties
	function automatic logic signed [SW-1:0] random_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		if (pick < 40)
			return SW'($urandom_range(4) - 2);
		return SW'($urandom);
	endfunction

	initial begin
		int n;
		int pause_at;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// reset sizes: one-sample maps, every sample ends a map
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(-16'sd1);

		// 3x3 maps in 2x2 tiles, two maps: ragged edges, all-minimum tiles, ties
		configure(9'd3, 9'd3, 9'd2, 9'd2);
		repeat (9)
			send_sample(16'sh8000);
		foreach (mixed_map[i])
			send_sample(mixed_map[i]);

		// receiver holds off while samples keep coming, so the block backs up
		set_idle(IDLE_NONE);
		configure(9'd1, 9'd2, 9'd1, 9'd3);
		set_idle(IDLE_NONE);
		hold_id <= hold_id + 1;
		repeat (40)
			send_sample(random_sample());

		// tallest maps with the largest tile, row count past its maximum
		configure(9'h1FF, 9'd1, 9'd8, 9'd1);
		repeat (256)
			send_sample(random_sample());

		// widest maps, zero tile side and zero map count
		configure(9'd1, 9'd256, 9'd0, 9'd0);
		repeat (256)
			send_sample(random_sample());

		// deepest stack, tile side past its maximum; runs past the stack end
		configure(9'd1, 9'd1, 9'h1FF, 9'h1FF);
		repeat (260)
			send_sample(random_sample());

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			configure(random_dim(12), random_dim(12), random_pool(), random_dim(3));
			n = $urandom_range(70, 110);
			pause_at = $urandom_range(n - 1);
			for (int i = 0; i < n; i++) begin
				if (i == pause_at) begin
					// sender drains the block; an unused index must not restart the scan
					settle();
					if ($urandom_range(1)) begin
						write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT,
							(1 << CFG_INDEX_W) - 1)), CFG_DATA_W'($urandom));
						cfg_valid <= 1'b0;
						repeat (SETTLE_CYCLES)
							@(posedge clk);
					end
				end
				send_sample(random_sample());
			end
		end

		settle();
		repeat (20)
			@(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
